/* rtl/half_precision_converter_unit_assert.svh */
// Assertion macros for the half precision converter.
`ifndef HALF_PRECISION_CONVERTER_UNIT_ASSERT_SVH
`define HALF_PRECISION_CONVERTER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define HPC_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HPC_ASSERT(label, clk, rst_n, prop, msg)
`define HPC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

/* rtl/hpc_pkg.sv */
`default_nettype none
package hpc_pkg;
    typedef enum logic [1:0] {
        FUNC_S2H = 2'd0,
        FUNC_D2H = 2'd1,
        FUNC_H2S = 2'd2,
        FUNC_H2D = 2'd3
    } t_func;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] operand;
    } t_in_word;

    localparam logic [15:0] H_INF = 16'h7c00;

    // Position of the highest set bit of a nonzero 10-bit value.
    function automatic logic [3:0] top_bit10(input logic [9:0] s);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (s[i]) begin
                p = 4'(i);
            end
        end
        return p;
    endfunction
endpackage
`default_nettype wire

/* rtl/hpc_if.sv */
`default_nettype none
interface hpc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] operand;
    modport source (output valid, output func, output operand, input ready);
    modport sink (input valid, input func, input operand, output ready);
endinterface

interface hpc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] converted;
    modport source (output valid, output converted, input ready);
    modport sink (input valid, input converted, output ready);
endinterface
`default_nettype wire

/* rtl/hpc_narrow.sv */
`default_nettype none
module hpc_narrow (
    input  wire logic        i_dbl,
    input  wire logic [63:0] i_operand,
    output logic [15:0]      o_half
);
    import hpc_pkg::*;

    logic        sgn;
    logic [10:0] ex;
    logic [51:0] sig;
    logic [53:0] m;
    logic [53:0] mr;
    logic [15:0] r;
    logic [5:0]  shamt;
    logic        sticky;
    logic [9:0]  top10;

    // Both formats are mapped onto an 11-bit exponent and a 52-bit significand.
    always_comb begin
        if (i_dbl) begin
            sgn = i_operand[63];
            ex  = i_operand[62:52];
            sig = i_operand[51:0];
        end else begin
            sgn = i_operand[31];
            ex  = (i_operand[30:23] == 8'hff) ? 11'h7ff : 11'(i_operand[30:23]) + 11'd896;
            sig = {i_operand[22:0], 29'd0};
        end
        top10  = sig[51:42];
        shamt  = 6'd0;
        m      = '0;
        mr     = '0;
        sticky = 1'b0;
        if (ex >= 11'd1039) begin
            if (ex != 11'h7ff || sig == '0) begin
                r = H_INF;
            end else begin
                r = H_INF | {6'd0, (top10 == 10'd0) ? 10'd1 : top10};
            end
        end else if (ex <= 11'd1008) begin
            if (ex < 11'd998) begin
                r = 16'd0;
            end else begin
                // Shift so the half ulp lands at bit 42, then round to nearest even.
                shamt  = 6'(11'd1008 - ex) + 6'd1;
                m      = {1'b1, sig, 1'b0} >> shamt;
                sticky = |(({1'b1, sig, 1'b0}) & ~({54{1'b1}} << shamt));
                if (m[42] && (sticky || |m[41:0] || m[43])) begin
                    mr = m + 54'(1) * (54'd1 << 43);
                end else begin
                    mr = m;
                end
                r = 16'(mr[53:43]);
            end
        end else begin
            m = {2'd0, sig};
            if (m[41] && (|m[40:0] || m[42])) begin
                mr = m + (54'd1 << 42);
            end else begin
                mr = m;
            end
            r = 16'({5'(ex - 11'd1008), 10'd0}) + 16'(mr[53:42]);
        end
        o_half = {sgn, 15'd0} + r;
    end
endmodule
`default_nettype wire

/* rtl/hpc_widen.sv */
`default_nettype none
module hpc_widen (
    input  wire logic        i_dbl,
    input  wire logic [15:0] i_half,
    output logic [63:0]      o_wide
);
    import hpc_pkg::*;

    logic        sgn;
    logic [4:0]  he;
    logic [9:0]  hs;
    logic [3:0]  p;
    logic [10:0] ex;
    logic [9:0]  fr;
    logic        zero;
    logic        spec;

    always_comb begin
        sgn  = i_half[15];
        he   = i_half[14:10];
        hs   = i_half[9:0];
        p    = top_bit10(hs);
        zero = 1'b0;
        spec = 1'b0;
        if (he == 5'd0) begin
            zero = (hs == 10'd0);
            ex   = 11'd999 + 11'(p);
            fr   = 10'((hs << (4'd10 - p)));
        end else if (he == 5'h1f) begin
            spec = 1'b1;
            ex   = 11'h7ff;
            fr   = hs;
        end else begin
            ex = 11'(he) + 11'd1008;
            fr = hs;
        end
        if (i_dbl) begin
            o_wide = zero ? {sgn, 63'd0} : {sgn, ex, fr, 42'd0};
        end else begin
            o_wide = zero ? {32'd0, sgn, 31'd0} :
                {32'd0, sgn, spec ? 8'hff : 8'(ex - 11'd896), fr, 13'd0};
        end
    end
endmodule
`default_nettype wire

/* rtl/half_precision_converter_unit.sv */
`default_nettype none
// Converts bit patterns between IEEE binary16 and binary32 or binary64, one word per clock
// cycle while the output is ready. A word is captured in an input register, converted by
// one pass of combinational logic and held in a result register that can stall alone.
`include "half_precision_converter_unit_assert.svh"
module half_precision_converter_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hpc_in_if.sink    i_in,
    hpc_out_if.source o_out
);
    import hpc_pkg::*;

    logic        r_in_v, r_out_v;
    t_in_word    r_in;
    logic [63:0] r_out;
    logic        adv;
    logic [15:0] narrow;
    logic [63:0] wide;
    logic [63:0] n_out;

    assign adv         = !r_out_v || o_out.ready;
    assign i_in.ready  = !r_in_v || adv;
    assign o_out.valid = r_out_v;
    assign o_out.converted = r_out;

    hpc_narrow u_narrow (.i_dbl(r_in.func == FUNC_D2H), .i_operand(r_in.operand),
        .o_half(narrow));
    hpc_widen u_widen (.i_dbl(r_in.func == FUNC_H2D), .i_half(r_in.operand[15:0]),
        .o_wide(wide));

    assign n_out = (r_in.func == FUNC_S2H || r_in.func == FUNC_D2H) ?
        {48'd0, narrow} : wide;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_v <= i_in.valid;
            end
            if (adv) begin
                r_out_v <= r_in_v;
            end
        end
        if (i_in.ready && i_in.valid) begin
            r_in <= '{func: i_in.func, operand: i_in.operand};
        end
        if (adv && r_in_v) begin
            r_out <= n_out;
        end
    end

    `HPC_ASSERT(a_hold, i_clk, i_rst_n, r_out_v && !o_out.ready |=> r_out_v && $stable(r_out), "result lost")
    `HPC_ASSERT(a_move, i_clk, i_rst_n, r_in_v && adv |=> r_out_v, "word dropped")
    `HPC_ASSERT(a_narrow, i_clk, i_rst_n, r_out_v && !o_out.ready && $past(r_in.func) == FUNC_S2H && $past(adv) |-> r_out[63:16] == 48'd0, "narrow result not zero-extended")
endmodule
`default_nettype wire

/* verif/half_precision_converter_unit_tb.sv */
`default_nettype none
module half_precision_converter_unit_tb;
    import hpc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    int   error_count;
    int   idle_cycles;
    bit   hold_off;

    hpc_in_if  in_ch();
    hpc_out_if out_ch();

    logic [63:0] converted_queue[$];

    half_precision_converter_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic int msb_index(input logic [9:0] s);
        int p;
        p = 0;
        for (int i = 0; i < 10; i++) begin
            if (s[i]) begin
                p = i;
            end
        end
        return p;
    endfunction

    function automatic logic [63:0] nan_to_half(input logic [15:0] sgn, input logic [9:0] top);
        logic [15:0] r;
        r = H_INF | {6'd0, top};
        if (top == 10'd0) begin
            r = r + 16'd1;
        end
        return {48'd0, sgn + r};
    endfunction

    function automatic logic [63:0] narrow_single(input logic [31:0] f);
        logic [15:0] sgn;
        logic [31:0] ex;
        logic [31:0] sig;
        logic [31:0] m;
        logic [31:0] e;
        sgn = {f[31], 15'd0};
        ex = f & 32'h7f800000;
        sig = f & 32'h007fffff;
        if (ex >= 32'h47800000) begin
            if (ex != 32'h7f800000 || sig == 0) begin
                return {48'd0, sgn + H_INF};
            end
            return nan_to_half(sgn, sig[22:13]);
        end
        if (ex <= 32'h38000000) begin
            if (ex < 32'h33000000) begin
                return {48'd0, sgn};
            end
            e = ex >> 23;
            m = (32'h00800000 + sig) >> ((32'd113 - e) & 32'd31);
            if ((m & 32'h3fff) != 32'h1000 || (f & 32'h7ff) != 0) begin
                m = m + 32'h1000;
            end
            return {48'd0, sgn} + {32'd0, m >> 13};
        end
        m = sig;
        if ((m & 32'h3fff) != 32'h1000) begin
            m = m + 32'h1000;
        end
        return {48'd0, sgn} + {32'd0, (ex - 32'h38000000) >> 13} + {32'd0, m >> 13};
    endfunction

    function automatic logic [63:0] narrow_double(input logic [63:0] d);
        logic [63:0] sgn;
        logic [63:0] ex;
        logic [63:0] sig;
        logic [63:0] m;
        logic [63:0] e;
        sgn = {48'd0, d[63], 15'd0};
        ex = d & 64'h7ff0000000000000;
        sig = d & 64'h000fffffffffffff;
        if (ex >= 64'h40f0000000000000) begin
            if (ex != 64'h7ff0000000000000 || sig == 0) begin
                return sgn + {48'd0, H_INF};
            end
            return nan_to_half(sgn[15:0], sig[51:42]);
        end
        if (ex <= 64'h3f00000000000000) begin
            if (ex < 64'h3e60000000000000) begin
                return sgn;
            end
            e = ex >> 52;
            m = (64'h0010000000000000 + sig) << ((e - 64'd998) & 64'd15);
            if ((m & 64'h003fffffffffffff) != 64'h0010000000000000) begin
                m = m + 64'h0010000000000000;
            end
            return sgn + ((m >> 53) & 64'hffff);
        end
        m = sig;
        if ((m & 64'h000007ffffffffff) != 64'h0000020000000000) begin
            m = m + 64'h0000020000000000;
        end
        return sgn + ((ex - 64'h3f00000000000000) >> 42) + (m >> 42);
    endfunction

    function automatic logic [63:0] widen_half(input logic [15:0] h, input bit to_double);
        logic [4:0]  he;
        logic [9:0]  hs;
        logic [9:0]  frac;
        logic [63:0] sgn;
        int          p;
        he = h[14:10];
        hs = h[9:0];
        sgn = to_double ? {h[15], 63'd0} : {32'd0, h[15], 31'd0};
        if (he == 5'd0) begin
            if (hs == 10'd0) begin
                return sgn;
            end
            p = msb_index(hs);
            frac = hs << (10 - p);
            if (to_double) begin
                return sgn | (64'(999 + p) << 52) | ({54'd0, frac} << 42);
            end
            return sgn | (64'(103 + p) << 23) | ({54'd0, frac} << 13);
        end
        if (he == 5'h1f) begin
            if (to_double) begin
                return sgn | 64'h7ff0000000000000 | ({54'd0, hs} << 42);
            end
            return sgn | 64'h7f800000 | ({54'd0, hs} << 13);
        end
        if (to_double) begin
            return sgn + (({49'd0, h[14:0]} + 64'hfc000) << 42);
        end
        return sgn + (({49'd0, h[14:0]} + 64'h1c000) << 13);
    endfunction

    function automatic logic [63:0] convert_word(input t_func fn, input logic [63:0] op);
        case (fn)
            FUNC_S2H: return narrow_single(op[31:0]);
            FUNC_D2H: return narrow_double(op);
            FUNC_H2S: return widen_half(op[15:0], 1'b0);
            default:  return widen_half(op[15:0], 1'b1);
        endcase
    endfunction

    task automatic send_word(input t_func fn, input logic [63:0] op);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.func    <= fn;
        in_ch.operand <= op;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        converted_queue.push_back(convert_word(fn, op));
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] random_wide();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        send_word(FUNC_S2H, 64'h0);
        send_word(FUNC_S2H, 64'hffffffff_80000000);
        send_word(FUNC_S2H, 64'h477fe000);
        send_word(FUNC_S2H, 64'h477ff000);
        send_word(FUNC_S2H, 64'h7f800000);
        send_word(FUNC_S2H, 64'hff800001);
        send_word(FUNC_S2H, 64'h7fc00000);
        send_word(FUNC_S2H, 64'h33000000);
        send_word(FUNC_S2H, 64'h33000001);
        send_word(FUNC_S2H, 64'h387fc000);
        send_word(FUNC_S2H, 64'h3f801000);
        send_word(FUNC_S2H, 64'h3f803000);
        send_word(FUNC_D2H, 64'h7ff0000000000001);
        send_word(FUNC_D2H, 64'hfff8000000000000);
        send_word(FUNC_D2H, 64'h40effc0000000000);
        send_word(FUNC_D2H, 64'h3e60000000000000);
        send_word(FUNC_D2H, 64'h3ff0020000000000);
        send_word(FUNC_D2H, 64'hffffffffffffffff);
        send_word(FUNC_H2S, 64'hffffffffffff8000);
        send_word(FUNC_H2S, 64'h0001);
        send_word(FUNC_H2S, 64'h83ff);
        send_word(FUNC_H2S, 64'h7c00);
        send_word(FUNC_H2D, 64'hfc01);
        send_word(FUNC_H2D, 64'h7bff);
        send_word(FUNC_H2D, 64'h0200);
    endtask

    task automatic test_random(input int count);
        t_func       fn;
        logic [63:0] op;
        logic [63:0] e;
        for (int n = 0; n < count; n++) begin
            fn = t_func'($urandom_range(0, 3));
            op = random_wide();
            if ($urandom_range(0, 3) != 0) begin
                if (fn == FUNC_S2H) begin
                    e = 64'($urandom_range(100, 145));
                    if ($urandom_range(0, 9) == 0) begin
                        e = 64'hff;
                    end
                    op[30:23] = e[7:0];
                    if ($urandom_range(0, 3) == 0) begin
                        op[11:0] = $urandom_range(0, 1) ? 12'h000 : 12'h800;
                    end
                end else if (fn == FUNC_D2H) begin
                    e = 64'($urandom_range(995, 1040));
                    if ($urandom_range(0, 9) == 0) begin
                        e = 64'h7ff;
                    end
                    op[62:52] = e[10:0];
                    if ($urandom_range(0, 3) == 0) begin
                        op[40:0] = $urandom_range(0, 1) ? 41'd0 : 41'h100_0000_0000;
                    end
                end else if ($urandom_range(0, 2) == 0) begin
                    op[14:10] = $urandom_range(0, 1) ? 5'h00 : 5'h1f;
                end
            end
            send_word(fn, op);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            test_random(20);
            begin
                repeat (60) @(negedge i_clk);
                hold_off = 1'b0;
            end
        join
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= (gap_length() == 0) || ($urandom_range(0, 1) == 1);
        end
    end

    always @(posedge i_clk) begin
        logic [63:0] want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (converted_queue.size() == 0) begin
                $error("converted: unexpected word %h", out_ch.converted);
                error_count++;
            end else begin
                want = converted_queue.pop_front();
                if (out_ch.converted !== want) begin
                    $error("converted: expected %h, actual %h", want, out_ch.converted);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 2000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        error_count   = 0;
        idle_cycles   = 0;
        hold_off      = 1'b0;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.func    = FUNC_S2H;
        in_ch.operand = 64'd0;
        out_ch.ready  = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_backpressure();
        test_random(660);
        in_ch.valid <= 1'b0;
        wait (converted_queue.size() == 0);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && converted_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
